@@ hw/rtl/crsi_pkg.sv @@
// shared types, constants and arithmetic helpers for the catmull-rom interpolator
// no dependencies
package crsi_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS = 16;
   localparam int MAX_SAMPLES = 31;
   localparam int CNT_WIDTH = 5;
   localparam int COEF_WIDTH = COORD_WIDTH + 4;
   localparam int ACC_WIDTH = COORD_WIDTH + 6;
   localparam int PROD_WIDTH = ACC_WIDTH + FRAC_BITS + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [CNT_WIDTH-1:0] PPS_RESET = CNT_WIDTH'(10);

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] ax;
      logic signed [COEF_WIDTH-1:0] bx;
      logic signed [COEF_WIDTH-1:0] cx;
      logic signed [COORD_WIDTH-1:0] p1x;
      logic signed [COEF_WIDTH-1:0] ay;
      logic signed [COEF_WIDTH-1:0] by;
      logic signed [COEF_WIDTH-1:0] cy;
      logic signed [COORD_WIDTH-1:0] p1y;
      logic [COORD_WIDTH-1:0] t1;
      logic signed [COORD_WIDTH:0] dt;
      logic [CNT_WIDTH-1:0] count;
      logic last;
   } job_type;

   typedef struct packed {
      logic [FRAC_BITS:0] quot;
      logic [CNT_WIDTH-1:0] rmd;
      logic [CNT_WIDTH-1:0] n;
   } step_type;

   // round to nearest of v * m / 2^FRAC_BITS
   function automatic logic signed [ACC_WIDTH-1:0] rnd_mul(
      input logic signed [ACC_WIDTH-1:0] v,
      input logic [FRAC_BITS-1:0] m
   );
      logic signed [PROD_WIDTH-1:0] p;
      logic signed [PROD_WIDTH-1:0] mm;
      mm = PROD_WIDTH'($signed({1'b0, m}));
      p = PROD_WIDTH'(v) * mm;
      p = p + (PROD_WIDTH'(1) <<< (FRAC_BITS - 1));
      p = p >>> FRAC_BITS;
      return ACC_WIDTH'(p);
   endfunction

   function automatic logic [COORD_WIDTH-1:0] sat_coord(
      input logic signed [ACC_WIDTH:0] v
   );
      logic signed [ACC_WIDTH:0] hi;
      logic signed [ACC_WIDTH:0] lo;
      hi = $signed((ACC_WIDTH+1)'({1'b0, {(COORD_WIDTH-1){1'b1}}}));
      lo = -hi - (ACC_WIDTH+1)'(1);
      if (v > hi) begin
         return hi[COORD_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[COORD_WIDTH-1:0];
      end
      return v[COORD_WIDTH-1:0];
   endfunction

endpackage

@@ hw/rtl/crsi_queue.sv @@
// short job queue between front and back
// depends on crsi_pkg
module crsi_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  crsi_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output crsi_pkg::job_type pop_job
);

   localparam int AW = $clog2(crsi_pkg::QUEUE_DEPTH);

   crsi_pkg::job_type slot_ff [crsi_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign push_ready = (fill_ff != (AW+1)'(crsi_pkg::QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_job = slot_ff[rd_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_in = do_push ? AW'(wr_ff + AW'(1)) : wr_ff;
      rd_in = do_pop ? AW'(rd_ff + AW'(1)) : rd_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

@@ hw/rtl/crsi_front.sv @@
// front end: accepts waypoints, keeps history, builds segment jobs, holds the sample step
// depends on crsi_pkg
module crsi_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [crsi_pkg::CNT_WIDTH-1:0]      csr_wdata,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [crsi_pkg::COORD_WIDTH-1:0]    in_x,
   input  logic [crsi_pkg::COORD_WIDTH-1:0]    in_y,
   input  logic [crsi_pkg::COORD_WIDTH-1:0]    in_t,
   input  logic                                in_last,
   output logic                                job_valid,
   input  logic                                job_ready,
   output crsi_pkg::job_type                   job,
   output crsi_pkg::step_type                  step
);

   localparam int CW = crsi_pkg::COORD_WIDTH;
   localparam int KW = crsi_pkg::COEF_WIDTH;
   localparam int NW = crsi_pkg::CNT_WIDTH;
   localparam int F = crsi_pkg::FRAC_BITS;
   localparam int DCW = $clog2(F + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_ISSUE = 1'b1;

   logic state_ff, state_in;
   logic [NW-1:0] pps_ff, n_eff;
   logic signed [CW-1:0] hx_ff [3];
   logic signed [CW-1:0] hy_ff [3];
   logic [CW-1:0] ht_ff [3];
   logic [1:0] seen_ff;
   logic signed [CW-1:0] nx_ff, ny_ff;
   logic [CW-1:0] nt_ff;
   logic nlast_ff;
   logic [2:0] pend_ff, pend_in, pend_new;
   logic accept, push, hist_upd;

   logic busy_ff;
   logic [DCW-1:0] dcnt_ff;
   logic [NW-1:0] drem_ff;
   logic [F:0] dquot_ff;
   logic [NW:0] dsh, ddiff;

   logic signed [CW-1:0] p0x, p1x, p2x, p3x, p0y, p1y, p2y, p3y;
   logic [CW-1:0] t1, t2;
   logic [2:0] cur;

   assign n_eff = (pps_ff > NW'(crsi_pkg::MAX_SAMPLES)) ? NW'(crsi_pkg::MAX_SAMPLES) : pps_ff;
   assign in_ready = (state_ff == S_IDLE) && !busy_ff;
   assign accept = in_valid && in_ready;

   // sample step: 2^F / n by restoring division
   assign dsh = {drem_ff, (dcnt_ff == DCW'(F))};
   assign ddiff = dsh - {1'b0, n_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pps_ff <= crsi_pkg::PPS_RESET;
         busy_ff <= 1'b1;
         dcnt_ff <= DCW'(F);
         drem_ff <= '0;
         dquot_ff <= '0;
      end else if (csr_we) begin
         pps_ff <= csr_wdata;
         busy_ff <= 1'b1;
         dcnt_ff <= DCW'(F);
         drem_ff <= '0;
         dquot_ff <= '0;
      end else if (busy_ff) begin
         if (dsh >= {1'b0, n_eff}) begin
            drem_ff <= ddiff[NW-1:0];
            dquot_ff <= {dquot_ff[F-1:0], 1'b1};
         end else begin
            drem_ff <= dsh[NW-1:0];
            dquot_ff <= {dquot_ff[F-1:0], 1'b0};
         end
         if (dcnt_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            dcnt_ff <= dcnt_ff - DCW'(1);
         end
      end
   end

   assign step.quot = dquot_ff;
   assign step.rmd = drem_ff;
   assign step.n = n_eff;

   // jobs: bit 0 previous segment, bit 1 final segment, bit 2 echo
   always_comb begin
      pend_new[0] = (seen_ff >= 2'd2) && (n_eff != '0);
      pend_new[1] = in_last && (seen_ff != 2'd0) && (n_eff != '0);
      pend_new[2] = in_last;
   end

   always_comb begin
      if (pend_ff[0]) begin
         cur = 3'b001;
      end else if (pend_ff[1]) begin
         cur = 3'b010;
      end else begin
         cur = 3'b100;
      end
   end

   always_comb begin
      p0x = nx_ff; p1x = nx_ff; p2x = nx_ff; p3x = nx_ff;
      p0y = ny_ff; p1y = ny_ff; p2y = ny_ff; p3y = ny_ff;
      t1 = nt_ff; t2 = nt_ff;
      if (cur[0]) begin
         p0x = (seen_ff == 2'd3) ? hx_ff[0] : hx_ff[1];
         p0y = (seen_ff == 2'd3) ? hy_ff[0] : hy_ff[1];
         p1x = hx_ff[1]; p1y = hy_ff[1];
         p2x = hx_ff[2]; p2y = hy_ff[2];
         t1 = ht_ff[1]; t2 = ht_ff[2];
      end else if (cur[1]) begin
         p0x = (seen_ff >= 2'd2) ? hx_ff[1] : hx_ff[2];
         p0y = (seen_ff >= 2'd2) ? hy_ff[1] : hy_ff[2];
         p1x = hx_ff[2]; p1y = hy_ff[2];
         t1 = ht_ff[2];
      end
   end

   always_comb begin
      job.ax = KW'(p2x) - KW'(p0x);
      job.bx = (KW'(p0x) <<< 1) - KW'(p1x) * KW'(5) + (KW'(p2x) <<< 2) - KW'(p3x);
      job.cx = KW'(p1x) * KW'(3) - KW'(p0x) - KW'(p2x) * KW'(3) + KW'(p3x);
      job.p1x = p1x;
      job.ay = KW'(p2y) - KW'(p0y);
      job.by = (KW'(p0y) <<< 1) - KW'(p1y) * KW'(5) + (KW'(p2y) <<< 2) - KW'(p3y);
      job.cy = KW'(p1y) * KW'(3) - KW'(p0y) - KW'(p2y) * KW'(3) + KW'(p3y);
      job.p1y = p1y;
      job.t1 = t1;
      job.dt = $signed({1'b0, t2}) - $signed({1'b0, t1});
      job.count = cur[2] ? NW'(1) : n_eff;
      job.last = ((pend_ff & ~cur) == 3'b000);
   end

   assign job_valid = (state_ff == S_ISSUE);
   assign push = job_valid && job_ready;
   assign pend_in = pend_ff & ~cur;
   assign hist_upd = (accept && (pend_new == 3'b000)) || (push && (pend_in == 3'b000));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (pend_new != 3'b000)) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (push && (pend_in == 3'b000)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            pend_ff <= pend_new;
         end else if (push) begin
            pend_ff <= pend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         nx_ff <= $signed(in_x);
         ny_ff <= $signed(in_y);
         nt_ff <= in_t;
         nlast_ff <= in_last;
      end
   end

   // history update uses the held waypoint, or the incoming one when no job is due
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            hx_ff[i] <= '0;
            hy_ff[i] <= '0;
            ht_ff[i] <= '0;
         end
      end else if (hist_upd) begin
         if (accept ? in_last : nlast_ff) begin
            seen_ff <= '0;
            for (int i = 0; i < 3; i++) begin
               hx_ff[i] <= '0;
               hy_ff[i] <= '0;
               ht_ff[i] <= '0;
            end
         end else begin
            hx_ff[0] <= hx_ff[1];
            hx_ff[1] <= hx_ff[2];
            hx_ff[2] <= accept ? $signed(in_x) : nx_ff;
            hy_ff[0] <= hy_ff[1];
            hy_ff[1] <= hy_ff[2];
            hy_ff[2] <= accept ? $signed(in_y) : ny_ff;
            ht_ff[0] <= ht_ff[1];
            ht_ff[1] <= ht_ff[2];
            ht_ff[2] <= accept ? in_t : nt_ff;
            if (seen_ff != 2'd3) begin
               seen_ff <= seen_ff + 2'd1;
            end
         end
      end
   end

endmodule

@@ hw/rtl/crsi_back.sv @@
// back end: steps through each job's samples and evaluates the curve in a stalling pipeline
// depends on crsi_pkg
module crsi_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             job_valid,
   output logic                             job_ready,
   input  crsi_pkg::job_type                job,
   input  crsi_pkg::step_type               step,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [crsi_pkg::COORD_WIDTH-1:0] out_x,
   output logic [crsi_pkg::COORD_WIDTH-1:0] out_y,
   output logic [crsi_pkg::COORD_WIDTH-1:0] out_t,
   output logic                             out_last
);

   localparam int CW = crsi_pkg::COORD_WIDTH;
   localparam int AW = crsi_pkg::ACC_WIDTH;
   localparam int NW = crsi_pkg::CNT_WIDTH;
   localparam int F = crsi_pkg::FRAC_BITS;

   crsi_pkg::job_type cur_ff;
   logic cur_valid_ff;
   logic [NW-1:0] j_ff;
   logic [F:0] m_ff, m_sum;
   logic [NW:0] r_sum, r_diff;
   logic [NW-1:0] r_ff;
   logic enable, issue, final_elem, load;

   logic s1_v_ff, s2_v_ff, s3_v_ff, s_last1_ff, s_last2_ff, s_last3_ff;
   logic [F-1:0] m1_ff, m2_ff;
   logic signed [AW-1:0] ux1_ff, bx1_ff, ax1_ff, uy1_ff, by1_ff, ay1_ff;
   logic signed [AW-1:0] vx2_ff, ax2_ff, vy2_ff, ay2_ff;
   logic signed [AW-1:0] wx3_ff, wy3_ff;
   logic signed [CW-1:0] px1_ff, px2_ff, px3_ff, py1_ff, py2_ff, py3_ff;
   logic signed [AW-1:0] tm1_ff, tm2_ff, tm3_ff, tm_calc;
   logic signed [AW:0] qx, qy;
   logic [CW-1:0] t_sat;

   logic out_v_ff;
   logic [CW-1:0] ox_ff, oy_ff, ot_ff;
   logic olast_ff;

   assign enable = !out_v_ff || out_ready;
   assign issue = enable && cur_valid_ff;
   assign final_elem = (j_ff == NW'(cur_ff.count - NW'(1)));
   assign load = (!cur_valid_ff || (issue && final_elem)) && job_valid;
   assign job_ready = !cur_valid_ff || (issue && final_elem);

   // next t step: m += q, remainder carried
   assign r_sum = {1'b0, r_ff} + {1'b0, step.rmd};
   assign r_diff = r_sum - {1'b0, step.n};

   always_comb begin
      m_sum = m_ff + step.quot;
      if (r_sum >= {1'b0, step.n}) begin
         m_sum = m_sum + (F+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else if (load) begin
         cur_valid_ff <= 1'b1;
      end else if (issue && final_elem) begin
         cur_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= job;
         j_ff <= '0;
         m_ff <= '0;
         r_ff <= '0;
      end else if (issue) begin
         j_ff <= j_ff + NW'(1);
         m_ff <= m_sum;
         r_ff <= (r_sum >= {1'b0, step.n}) ? r_diff[NW-1:0] : r_sum[NW-1:0];
      end
   end

   assign tm_calc = AW'($signed({1'b0, cur_ff.t1}))
                  + crsi_pkg::rnd_mul(AW'(cur_ff.dt), m_ff[F-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (enable) begin
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         m1_ff <= m_ff[F-1:0];
         ux1_ff <= crsi_pkg::rnd_mul(AW'(cur_ff.cx), m_ff[F-1:0]);
         uy1_ff <= crsi_pkg::rnd_mul(AW'(cur_ff.cy), m_ff[F-1:0]);
         bx1_ff <= AW'(cur_ff.bx);
         by1_ff <= AW'(cur_ff.by);
         ax1_ff <= AW'(cur_ff.ax);
         ay1_ff <= AW'(cur_ff.ay);
         px1_ff <= cur_ff.p1x;
         py1_ff <= cur_ff.p1y;
         tm1_ff <= tm_calc;
         s_last1_ff <= cur_ff.last && final_elem;

         m2_ff <= m1_ff;
         vx2_ff <= crsi_pkg::rnd_mul(bx1_ff + ux1_ff, m1_ff);
         vy2_ff <= crsi_pkg::rnd_mul(by1_ff + uy1_ff, m1_ff);
         ax2_ff <= ax1_ff;
         ay2_ff <= ay1_ff;
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         tm2_ff <= tm1_ff;
         s_last2_ff <= s_last1_ff;

         wx3_ff <= crsi_pkg::rnd_mul(ax2_ff + vx2_ff, m2_ff);
         wy3_ff <= crsi_pkg::rnd_mul(ay2_ff + vy2_ff, m2_ff);
         px3_ff <= px2_ff;
         py3_ff <= py2_ff;
         tm3_ff <= tm2_ff;
         s_last3_ff <= s_last2_ff;
      end
   end

   assign qx = ((AW+1)'(px3_ff) <<< 1) + (AW+1)'(wx3_ff) + (AW+1)'(1);
   assign qy = ((AW+1)'(py3_ff) <<< 1) + (AW+1)'(wy3_ff) + (AW+1)'(1);

   always_comb begin
      if (tm3_ff < 0) begin
         t_sat = '0;
      end else if (tm3_ff > $signed(AW'({1'b0, {CW{1'b1}}}))) begin
         t_sat = '1;
      end else begin
         t_sat = tm3_ff[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (enable) begin
         out_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ox_ff <= crsi_pkg::sat_coord(qx >>> 1);
         oy_ff <= crsi_pkg::sat_coord(qy >>> 1);
         ot_ff <= t_sat;
         olast_ff <= s_last3_ff;
      end
   end

   assign out_valid = out_v_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_t = ot_ff;
   assign out_last = olast_ff;

endmodule

@@ hw/rtl/catmull_rom_spline_interpolator.sv @@
// catmull-rom interpolator top level: front end, job queue, sample pipeline
// depends on crsi_pkg, crsi_front, crsi_queue, crsi_back
// throughput: one sample per cycle from the back pipeline while rsp_tready is held high; a waypoint
//    causes up to three jobs, and the front takes no new waypoint until it has built them all,
//    one job per cycle while the queue has room
// reset: history, points count and queue clear; samples per segment returns to 10 and
//    the step divider then runs to completion before the first waypoint is taken
module catmull_rom_spline_interpolator (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // waypoint_x, waypoint_y, waypoint_time
   input  logic         req_tlast,   // path_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // sample_x, sample_y, sample_time
   output logic         rsp_tlast    // run_last
);

   localparam int CW = crsi_pkg::COORD_WIDTH;

   crsi_pkg::job_type push_job, pop_job;
   crsi_pkg::step_type step;
   logic push_valid, push_ready, pop_valid, pop_ready;

   crsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_x      (req_tdata[CW-1:0]),
      .in_y      (req_tdata[2*CW-1:CW]),
      .in_t      (req_tdata[3*CW-1:2*CW]),
      .in_last   (req_tlast),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job       (push_job),
      .step      (step)
   );

   crsi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   crsi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job       (pop_job),
      .step      (step),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (rsp_tdata[CW-1:0]),
      .out_y     (rsp_tdata[2*CW-1:CW]),
      .out_t     (rsp_tdata[3*CW-1:2*CW]),
      .out_last  (rsp_tlast)
   );

endmodule

@@ test/tb.sv @@
// self-checking testbench for catmull_rom_spline_interpolator: streams timed waypoints,
// predicts every spline sample in place and compares each sample transaction
// depends on crsi_pkg and the interpolator rtl
module tb;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] tm;
      logic        path_end;
      logic        is_cfg;
      logic [4:0]  cfg;
   } waypoint_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] tm;
      logic        run_last;
   } sample_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [4:0]  csr_wdata = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic        rsp_tlast;

   catmull_rom_spline_interpolator u_dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   waypoint_type pending_q[$];
   sample_type   expected_samples[$];
   int        errors = 0;
   int        samples_seen = 0;
   int        waypoints_sent = 0;
   int        hold_off = 0;
   bit        hold_done = 0;
   int        gap = 0;
   int        burst = 0;
   bit        stim_done = 0;

   // predictor state
   longint hist_x[3], hist_y[3], hist_t[3];
   int     seen = 0;
   int     pps = 10;

   function automatic longint round_mul(longint v, longint m);
      longint lo, hi;
      lo = v & 64'hffff;
      hi = (v - lo) / 65536;
      return hi * m + ((lo * m + 32768) >>> 16);
   endfunction

   function automatic logic [31:0] clamp_signed(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   function automatic longint curve(longint p0, p1, p2, p3, longint m);
      longint a, b, c, u, v, w, q;
      a = p2 - p0;
      b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c = -p0 + 3 * p1 - 3 * p2 + p3;
      u = round_mul(c, m);
      v = round_mul(b + u, m);
      w = round_mul(a + v, m);
      q = 2 * p1 + w + 1;
      return (q - (q & 1)) / 2;
   endfunction

   function automatic void predict_segment(longint x0, x1, x2, x3, y0, y1, y2, y3,
                                           longint t1, t2);
      int n;
      longint m, tmv;
      sample_type s;
      n = pps;
      for (int j = 0; j < n; j++) begin
         m = (longint'(j) << 16) / n;
         tmv = t1 + round_mul(t2 - t1, m);
         if (tmv < 0) s.tm = 0;
         else if (tmv > 64'hffffffff) s.tm = '1;
         else s.tm = tmv[31:0];
         s.x = clamp_signed(curve(x0, x1, x2, x3, m));
         s.y = clamp_signed(curve(y0, y1, y2, y3, m));
         s.run_last = 0;
         expected_samples = {expected_samples, s};
      end
   endfunction

   function automatic void predict_waypoint(waypoint_type w);
      longint nx, ny, nt;
      int prior_count, i0;
      sample_type s;
      nx = longint'($signed(w.x));
      ny = longint'($signed(w.y));
      nt = longint'({32'd0, w.tm});
      prior_count = expected_samples.size();
      if (seen >= 2) begin
         i0 = (seen >= 3) ? 0 : 1;
         predict_segment(hist_x[i0], hist_x[1], hist_x[2], nx,
                         hist_y[i0], hist_y[1], hist_y[2], ny, hist_t[1], hist_t[2]);
         if (w.path_end)
            predict_segment(hist_x[1], hist_x[2], nx, nx,
                            hist_y[1], hist_y[2], ny, ny, hist_t[2], nt);
      end else if (seen == 1 && w.path_end) begin
         predict_segment(hist_x[2], hist_x[2], nx, nx,
                         hist_y[2], hist_y[2], ny, ny, hist_t[2], nt);
      end
      if (w.path_end) begin
         s.x = w.x; s.y = w.y; s.tm = w.tm; s.run_last = 0;
         expected_samples = {expected_samples, s};
      end
      if (expected_samples.size() > prior_count)
         expected_samples[expected_samples.size()-1].run_last = 1;
      if (w.path_end) begin
         hist_x = '{0, 0, 0}; hist_y = '{0, 0, 0}; hist_t = '{0, 0, 0};
         seen = 0;
      end else begin
         hist_x = '{hist_x[1], hist_x[2], nx};
         hist_y = '{hist_y[1], hist_y[2], ny};
         hist_t = '{hist_t[1], hist_t[2], nt};
         if (seen < 3) seen++;
      end
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
      endcase
   endfunction

   task automatic add_point(logic [31:0] x, y, tm, logic pe);
      waypoint_type w;
      w.x = x; w.y = y; w.tm = tm; w.path_end = pe; w.is_cfg = 0; w.cfg = 0;
      pending_q = {pending_q, w};
   endtask

   task automatic add_config(logic [4:0] v);
      waypoint_type w;
      w = '{default: 0};
      w.is_cfg = 1; w.cfg = v;
      pending_q = {pending_q, w};
   endtask

   task automatic add_path(int len);
      logic [31:0] tm;
      tm = $urandom;
      for (int i = 0; i < len; i++) begin
         add_point(rand_coord(), rand_coord(), tm, i == len - 1);
         tm = ($urandom_range(0, 3) == 0) ? $urandom : tm + $urandom_range(0, 32'h40000);
      end
   endtask

   // driver: bursts and gaps; config writes only once the block has drained
   always @(posedge clock) begin
      bit write_cfg;
      write_cfg = 0;
      if (reset) begin
         req_tvalid <= 0;
      end else if (req_tvalid && !req_tready) begin
      end else begin
         if (req_tvalid) waypoints_sent++;
         if (gap > 0) begin
            gap--;
            req_tvalid <= 0;
         end else if (pending_q.size() == 0) begin
            req_tvalid <= 0;
            stim_done <= 1;
         end else if (pending_q[0].is_cfg) begin
            req_tvalid <= 0;
            if (!req_tvalid && expected_samples.size() == 0) begin
               if (burst > 12) begin
                  write_cfg = 1;
                  csr_wdata <= pending_q[0].cfg;
                  pps <= pending_q[0].cfg;
                  void'(pending_q.pop_front());
                  burst = 0;
               end else begin
                  burst++;
               end
            end
         end else begin
            req_tvalid <= 1;
            req_tdata <= {pending_q[0].tm, pending_q[0].y, pending_q[0].x};
            req_tlast <= pending_q[0].path_end;
            predict_waypoint(pending_q.pop_front());
            if ($urandom_range(0, 7) == 0) gap = $urandom_range(1, 20);
         end
      end
      csr_we <= write_cfg;
   end

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 0;
      end else if (!hold_done && waypoints_sent >= 40) begin
         hold_done = 1;
         hold_off = 400;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0) || (samples_seen % 200 > 120);
      end
   end

   // monitor
   always @(posedge clock) begin
      sample_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x = rsp_tdata[31:0];
         got.y = rsp_tdata[63:32];
         got.tm = rsp_tdata[95:64];
         got.run_last = rsp_tlast;
         samples_seen++;
         if (expected_samples.size() == 0) begin
            errors++;
            $display("%0t unexpected sample x=%h y=%h t=%h last=%b",
                     $time, got.x, got.y, got.tm, got.run_last);
         end else begin
            want = expected_samples.pop_front();
            if (got.x !== want.x)
               $display("%0t sample_x expected %h actual %h", $time, want.x, got.x);
            if (got.y !== want.y)
               $display("%0t sample_y expected %h actual %h", $time, want.y, got.y);
            if (got.tm !== want.tm)
               $display("%0t sample_time expected %h actual %h", $time, want.tm, got.tm);
            if (got.run_last !== want.run_last)
               $display("%0t run_last expected %b actual %b",
                        $time, want.run_last, got.run_last);
            if (got !== want) errors++;
         end
      end
   end

   initial begin
      int count;
      // directed: lone points, two-point path, extremes, zero and large settings
      add_point(32'h7fffffff, 32'h80000000, 32'hffffffff, 1);
      add_point(32'h00010000, 32'hffff0000, 32'h0, 0);
      add_point(32'h80000000, 32'h7fffffff, 32'hffffffff, 1);
      add_point(32'h7fffffff, 32'h7fffffff, 32'h0, 0);
      add_point(32'h80000000, 32'h80000000, 32'h10000, 0);
      add_point(32'h7fffffff, 32'h7fffffff, 32'hffffffff, 0);
      add_point(32'h80000000, 32'h80000000, 32'h0, 1);
      add_config(5'd0);
      add_point(32'h00020000, 32'h00030000, 32'h5, 0);
      add_point(32'h00040000, 32'h00050000, 32'h6, 0);
      add_point(32'h00060000, 32'h00070000, 32'h7, 0);
      add_point(32'h00080000, 32'h00090000, 32'h8, 1);
      add_point(32'h12345678, 32'h9abcdef0, 32'h1, 1);
      add_config(5'd31);
      add_path(4);
      add_config(5'd1);
      add_path(3);
      add_path(1);
      count = 20;
      while (count < 300) begin
         if ($urandom_range(0, 5) == 0) add_config(5'($urandom_range(0, 31)));
         else if ($urandom_range(0, 2) == 0) add_config(5'($urandom_range(1, 6)));
         begin
            int len;
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            if ($urandom_range(0, 9) == 0) begin
               for (int i = 0; i < len; i++)
                  add_point($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
            end else begin
               add_path(len);
            end
            count += len;
         end
      end
      add_config(5'd10);
      add_path(3);
      repeat (8) @(posedge clock);
      reset <= 0;
      wait (stim_done && !req_tvalid && expected_samples.size() == 0);
      repeat (50) @(posedge clock);
      $display("tb: %0d waypoints sent, %0d samples checked across several spline settings",
               waypoints_sent, samples_seen);
      if (errors == 0 && expected_samples.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #4000000;
      $display("tb: errors");
      $finish;
   end

endmodule

@@ catmull_rom_spline_interpolator.f @@
hw/rtl/crsi_pkg.sv
hw/rtl/crsi_queue.sv
hw/rtl/crsi_front.sv
hw/rtl/crsi_back.sv
hw/rtl/catmull_rom_spline_interpolator.sv
test/tb.sv
